// ----- hw/rtl/egp_pkg.sv -----
// Shared widths, register indexes, stage map, configuration record and
// divider step functions of the Euclidean gate pattern block.
// No dependencies.
package egp_pkg;

  // Field and port widths
  localparam int CFG_W  = 9;
  localparam int IDX_W  = 2;
  localparam int STEP_W = 8;

  // Remainder width (divisors up to one past the longest pattern)
  localparam int R_W = CFG_W + 1;
  // Dividend shift width of the pattern-position divider
  localparam int S_W = CFG_W;

  localparam int DEFAULT_MAX_STEPS = 256;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [IDX_W-1:0] REG_PULSE_COUNT    = 2'd1;
  localparam logic [IDX_W-1:0] REG_ROTATION       = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0]  RST_PATTERN_LENGTH = 9'd16;
  localparam logic [STEP_W-1:0] RST_PULSE_COUNT    = 8'd0;
  localparam logic [STEP_W-1:0] RST_ROTATION       = 8'd0;

  // Stage map: step mod length, position, group select, position divider
  localparam int ST_POS     = STEP_W;
  localparam int ST_SEL     = ST_POS + 1;
  localparam int NUM_STAGES = ST_SEL + 1 + S_W;

  // Values derived from the registers, stable while ready is set
  typedef struct packed {
    logic           ready;
    logic [R_W-1:0] len;
    logic [R_W-1:0] rot;
    logic [R_W-1:0] lead;
    logic [R_W-1:0] big;
    logic [R_W-1:0] base;
    logic           sparse;
    logic           all_on;
    logic           all_off;
  } egp_pat_t;

  // One restoring-division step: shift in a bit, subtract if it fits
  function automatic logic [R_W-1:0] rem_step(input logic [R_W-1:0] r,
                                              input logic b,
                                              input logic [R_W-1:0] d);
    logic [R_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[R_W-1:0];
  endfunction

  // Quotient bit of the same step
  function automatic logic quo_bit(input logic [R_W-1:0] r,
                                   input logic b,
                                   input logic [R_W-1:0] d);
    return {r, b} >= {1'b0, d};
  endfunction

endpackage

// ----- hw/rtl/egp_setup.sv -----
// Configuration registers and the derived pattern values (rotation mod
// length, group sizes, leading span). Depends on egp_pkg.
module egp_setup #(
  parameter int MAX_STEPS = egp_pkg::DEFAULT_MAX_STEPS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [egp_pkg::IDX_W-1:0]  cfg_index,
  input  logic [egp_pkg::CFG_W-1:0]  cfg_data,
  output egp_pkg::egp_pat_t          pat
);

  typedef enum logic [2:0] {S_LOAD, S_PREP, S_DIV, S_BASE, S_MUL, S_READY} state_t;

  state_t                       state;
  logic [$clog2(egp_pkg::S_W)-1:0] cnt;

  logic [egp_pkg::CFG_W-1:0]  pattern_length;
  logic [egp_pkg::STEP_W-1:0] pulse_count;
  logic [egp_pkg::STEP_W-1:0] rotation;

  logic [egp_pkg::R_W-1:0] len;
  logic [egp_pkg::R_W-1:0] den;
  logic [egp_pkg::R_W-1:0] r1;
  logic [egp_pkg::R_W-1:0] r2;
  logic [egp_pkg::S_W-1:0] s1;
  logic [egp_pkg::S_W-1:0] s2;
  logic [egp_pkg::S_W-1:0] q;
  logic [egp_pkg::R_W-1:0] base;
  logic [egp_pkg::R_W-1:0] big;
  logic [egp_pkg::R_W-1:0] lead;
  logic                    sparse;
  logic                    all_on;
  logic                    all_off;

  logic [egp_pkg::R_W-1:0] len_sat;
  logic [egp_pkg::R_W-1:0] pulses;
  logic [egp_pkg::R_W-1:0] pauses;
  logic                    sparse_next;

  // Saturate the length and split the pattern into pulses and pauses
  always_comb begin
    len_sat = (int'(pattern_length) > MAX_STEPS) ? egp_pkg::R_W'(MAX_STEPS)
                                                 : egp_pkg::R_W'(pattern_length);
    pulses      = egp_pkg::R_W'(pulse_count);
    pauses      = len - pulses;
    sparse_next = pauses >= pulses;
  end

  // Register writes and the derivation sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_LOAD;
      cnt            <= '0;
      pattern_length <= egp_pkg::RST_PATTERN_LENGTH;
      pulse_count    <= egp_pkg::RST_PULSE_COUNT;
      rotation       <= egp_pkg::RST_ROTATION;
    end else if (cfg_we) begin
      // A write restarts the derivation
      state <= S_LOAD;
      unique case (cfg_index)
        egp_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data;
        egp_pkg::REG_PULSE_COUNT:    pulse_count    <= egp_pkg::STEP_W'(cfg_data);
        egp_pkg::REG_ROTATION:       rotation       <= egp_pkg::STEP_W'(cfg_data);
        default: begin
        end
      endcase
    end else begin
      unique case (state)
        S_LOAD: begin
          len     <= len_sat;
          all_off <= pulse_count == '0;
          all_on  <= egp_pkg::R_W'(pulse_count) >= len_sat;
          state   <= S_PREP;
        end
        S_PREP: begin
          sparse <= sparse_next;
          den    <= sparse_next ? pulses : pauses;
          s2     <= sparse_next ? egp_pkg::S_W'(pauses) : egp_pkg::S_W'(pulses - pauses);
          s1     <= egp_pkg::S_W'(rotation);
          r1     <= '0;
          r2     <= '0;
          q      <= '0;
          cnt    <= '0;
          state  <= S_DIV;
        end
        S_DIV: begin
          r1  <= egp_pkg::rem_step(r1, s1[egp_pkg::S_W-1], len);
          s1  <= s1 << 1;
          r2  <= egp_pkg::rem_step(r2, s2[egp_pkg::S_W-1], den);
          q   <= {q[egp_pkg::S_W-2:0], egp_pkg::quo_bit(r2, s2[egp_pkg::S_W-1], den)};
          s2  <= s2 << 1;
          cnt <= cnt + 1'b1;
          if (cnt == ($clog2(egp_pkg::S_W))'(egp_pkg::S_W - 1)) state <= S_BASE;
        end
        S_BASE: begin
          base  <= egp_pkg::R_W'(q) + (sparse ? egp_pkg::R_W'(1) : egp_pkg::R_W'(2));
          big   <= egp_pkg::R_W'(q) + (sparse ? egp_pkg::R_W'(2) : egp_pkg::R_W'(3));
          state <= S_MUL;
        end
        S_MUL: begin
          lead  <= egp_pkg::R_W'(r2 * big);
          state <= S_READY;
        end
        S_READY: begin
          state <= S_READY;
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign pat.ready   = state == S_READY;
  assign pat.len     = len;
  assign pat.rot     = r1;
  assign pat.lead    = lead;
  assign pat.big     = big;
  assign pat.base    = base;
  assign pat.sparse  = sparse;
  assign pat.all_on  = all_on;
  assign pat.all_off = all_off;

endmodule

// ----- hw/rtl/euclidean_gate_pattern_core.sv -----
// Top level of the Euclidean gate pattern block: step query pipeline and
// output register. Depends on egp_pkg and egp_setup.
//
// Usage:
//   Write pattern_length, pulse_count and rotation through cfg_we /
//   cfg_index / cfg_data while no query is in flight. After each write,
//   and after reset, step_ready stays low while the setup sequencer
//   derives the rotation mod length and the group sizes with two
//   bit-serial dividers.
//   A query enters on step_valid & step_ready carrying step_index; its
//   gate bit leaves on gate_valid & gate_ready.
//   The pipeline is 8 stages of step mod length (one remainder bit
//   each), a position stage, a group-select stage, 9 stages of position
//   mod group size and the output register.
//   Throughput is one query per cycle while step_ready is high. Each stage
//   holds its item while the stage after it is full and stalled, so
//   queries keep entering into empty stages while gate_ready is low.
//   Reset empties the pipeline and restores the register defaults
//   (length 16, no pulses, no rotation).
module euclidean_gate_pattern_core #(
  parameter int MAX_STEPS = egp_pkg::DEFAULT_MAX_STEPS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [egp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [egp_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        step_valid,
  output logic                        step_ready,
  input  logic [egp_pkg::STEP_W-1:0]  step_index,
  output logic                        gate_valid,
  input  logic                        gate_ready,
  output logic                        gate
);

  localparam int NS = egp_pkg::NUM_STAGES;

  egp_pkg::egp_pat_t pat;

  logic [NS-1:0]           vld;
  logic [egp_pkg::R_W-1:0] rr [NS];
  logic [egp_pkg::S_W-1:0] ss [NS];
  logic [NS-1:0]           sl;

  logic [NS-1:0]           src_v;
  logic [egp_pkg::R_W-1:0] src_r [NS];
  logic [egp_pkg::S_W-1:0] src_s [NS];
  logic [NS-1:0]           src_l;

  logic [egp_pkg::R_W-1:0] nr [NS];
  logic [egp_pkg::S_W-1:0] ns [NS];
  logic [NS-1:0]           nl;

  logic [NS-1:0]           take;
  logic                    take_out;
  logic                    gate_next;
  logic [egp_pkg::R_W-1:0] last_rem;

  egp_setup #(
    .MAX_STEPS(MAX_STEPS)
  ) u_setup (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pat      (pat)
  );

  // A stage loads when some stage from it onward is empty or the output moves
  always_comb begin
    take_out = !gate_valid || gate_ready;
    for (int i = 0; i < NS; i++) begin
      take[i] = take_out || (((~vld) >> i) != '0);
    end
  end

  assign step_ready = take[0] && pat.ready;

  // Feed each stage from the one before it, stage 0 from the port
  always_comb begin
    src_v[0] = step_valid && step_ready;
    src_r[0] = '0;
    src_s[0] = {step_index, 1'b0};
    src_l[0] = 1'b0;
    for (int i = 1; i < NS; i++) begin
      src_v[i] = vld[i-1];
      src_r[i] = rr[i-1];
      src_s[i] = ss[i-1];
      src_l[i] = sl[i-1];
    end
  end

  // Stage work: remainder bits, position, group select, remainder bits
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      nr[i] = src_r[i];
      ns[i] = src_s[i];
      nl[i] = src_l[i];
      if (i < egp_pkg::ST_POS) begin
        nr[i] = egp_pkg::rem_step(src_r[i], src_s[i][egp_pkg::S_W-1], pat.len);
        ns[i] = src_s[i] << 1;
      end else if (i == egp_pkg::ST_POS) begin
        nr[i] = (src_r[i] >= pat.rot) ? src_r[i] - pat.rot
                                      : src_r[i] + pat.len - pat.rot;
      end else if (i == egp_pkg::ST_SEL) begin
        nl[i] = src_r[i] < pat.lead;
        nr[i] = '0;
        ns[i] = nl[i] ? egp_pkg::S_W'(src_r[i]) : egp_pkg::S_W'(src_r[i] - pat.lead);
      end else begin
        nr[i] = egp_pkg::rem_step(src_r[i], src_s[i][egp_pkg::S_W-1],
                                  src_l[i] ? pat.big : pat.base);
        ns[i] = src_s[i] << 1;
      end
    end
  end

  // Advance the stages
  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (take[i]) begin
        vld[i] <= src_v[i];
      end
      if (take[i]) begin
        rr[i] <= nr[i];
        ss[i] <= ns[i];
        sl[i] <= nl[i];
      end
    end
  end

  // Offset within the group decides the gate, unless the pattern is all on or all off
  always_comb begin
    last_rem = rr[NS-1];
    if (pat.all_on) begin
      gate_next = 1'b1;
    end else if (pat.all_off) begin
      gate_next = 1'b0;
    end else if (pat.sparse) begin
      gate_next = last_rem == '0;
    end else begin
      gate_next = last_rem != egp_pkg::R_W'(1);
    end
  end

  // Output register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_valid <= 1'b0;
    end else if (take_out) begin
      gate_valid <= vld[NS-1];
    end
    if (take_out) begin
      gate <= gate_next;
    end
  end

endmodule

// ----- hw/rtl/egp_checker.sv -----
// Port-level checks of the Euclidean gate pattern block and the bind that
// attaches them to the top level. Depends on the top level's port names.
module egp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_we,
  input logic                        step_ready,
  input logic                        gate_valid,
  input logic                        gate_ready,
  input logic                        gate
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    gate_valid && !gate_ready |=> gate_valid && $stable(gate))
    else $error("stalled gate item changed or dropped");

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !gate_valid)
    else $error("result item present right after reset");

  // Reset starts the derivation, so no item enters
  a_rst_busy: assert property (@(posedge clk)
    $past(rst) |-> !step_ready)
    else $error("item taken before setup after reset");

  // A register write blocks input while the pattern is derived again
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !step_ready ##1 !step_ready)
    else $error("item taken during setup after a register write");

endmodule

bind euclidean_gate_pattern_core egp_checker u_egp_checker (.*);
